>>> rtl/spqt_pkg.sv
// ----------------------------------------------------------------------------
// spqt_pkg: shared types and constants for the sorted priority task queue
// Capacity, command and status codes, and the entry and control structs
// that pass between the top level and the row of queue cells.
// ----------------------------------------------------------------------------
package spqt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int PRI_W    = 8;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } stat_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  // Broadcast to every cell for the request being applied
  typedef struct packed {
    cmd_t             op;
    logic             act;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } ctl_t;

  // Flags a cell hands to its right-hand neighbor
  typedef struct packed {
    logic shift;
    logic found;
  } link_t;

endpackage

>>> rtl/sorted_priority_task_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_task_queue: bounded priority queue kept sorted in a cell row
// Takes one request per cycle while the output register is empty or being
// read; each result appears in the cycle after its request, from an output register.
// ----------------------------------------------------------------------------
// The queue is a row of CAPACITY cells, cell 0 at the head, kept in rising
// priority order with ties in arrival order. Every cell compares its entry
// with the request in the same cycle: an insert lands at the first cell
// holding a larger priority and the cells after it shift right; a pop or a
// remove shifts the cells behind the taken entry left. A remove finds the
// first matching id by a found flag handed from cell to cell along the row.
// A new request is taken in every cycle that the output register is empty
// or being read; the result follows in the cycle after its request.
module sorted_priority_task_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [spqt_pkg::CMD_W-1:0]    command,
  input  logic [spqt_pkg::ID_W-1:0]     task_id,
  input  logic [spqt_pkg::PRI_W-1:0]    priority_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spqt_pkg::STAT_W-1:0]   status,
  output logic [spqt_pkg::ID_W-1:0]     removed_id,
  output logic [spqt_pkg::PRI_W-1:0]    removed_priority,
  output logic [spqt_pkg::ECNT_W-1:0]   entry_count
);

  localparam int N = spqt_pkg::CAPACITY;

  logic [spqt_pkg::CNT_W-1:0] count;
  logic [spqt_pkg::CNT_W-1:0] count_next;
  logic                       in_fire;
  logic                       full;
  logic                       empty;
  spqt_pkg::cmd_t             op;
  spqt_pkg::ctl_t             ctl;
  spqt_pkg::stat_t            stat_next;
  spqt_pkg::entry_t           rem_next;
  spqt_pkg::entry_t           hit_ent;
  spqt_pkg::entry_t           cell_ent  [N];
  spqt_pkg::link_t            cell_link [N];
  logic [N-1:0]               hit;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign op       = spqt_pkg::cmd_t'(command);
  assign full     = (count == spqt_pkg::CNT_W'(N));
  assign empty    = (count == '0);

  // Request broadcast; refused or empty-queue requests leave the cells alone
  always_comb begin
    ctl.op  = op;
    ctl.id  = task_id;
    ctl.pri = priority_req;
    ctl.act = in_fire && !((op == spqt_pkg::CMD_INSERT) && full) &&
              !((op != spqt_pkg::CMD_INSERT) && empty);
  end

  // Row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    spqt_pkg::entry_t left_ent;
    spqt_pkg::link_t  left_link;
    spqt_pkg::entry_t right_ent;

    if (i == 0) begin : g_head
      assign left_ent  = '0;
      assign left_link = '0;
    end else begin : g_body
      assign left_ent  = cell_ent[i-1];
      assign left_link = cell_link[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_mid
      assign right_ent = cell_ent[i+1];
    end

    spqt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (count > spqt_pkg::CNT_W'(i)),
      .left_ent  (left_ent),
      .left_link (left_link),
      .right_ent (right_ent),
      .ent       (cell_ent[i]),
      .link      (cell_link[i]),
      .first_hit (hit[i])
    );
  end

  // Select the entry at the first id match
  always_comb begin
    hit_ent = '0;
    for (int i = 0; i < N; i++) begin
      if (hit[i]) begin
        hit_ent = hit_ent | cell_ent[i];
      end
    end
  end

  // Result and new count
  always_comb begin
    stat_next  = spqt_pkg::ST_OK;
    rem_next   = '0;
    count_next = count;
    case (op)
      spqt_pkg::CMD_INSERT: begin
        if (full) begin
          stat_next = spqt_pkg::ST_FULL;
        end else begin
          count_next = count + spqt_pkg::CNT_W'(1);
        end
      end
      spqt_pkg::CMD_POP: begin
        if (empty) begin
          stat_next = spqt_pkg::ST_EMPTY;
        end else begin
          rem_next   = cell_ent[0];
          count_next = count - spqt_pkg::CNT_W'(1);
        end
      end
      spqt_pkg::CMD_REMOVE: begin
        if (empty) begin
          stat_next = spqt_pkg::ST_EMPTY;
        end else if (!cell_link[N-1].found) begin
          stat_next = spqt_pkg::ST_NOT_FOUND;
        end else begin
          rem_next   = hit_ent;
          count_next = count - spqt_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Count and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status           <= stat_next;
      removed_id       <= rem_next.id;
      removed_priority <= rem_next.pri;
      entry_count      <= spqt_pkg::ECNT_W'(count_next);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spqt_pkg::CNT_W'(N))
    else $error("queue count exceeds capacity");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit))
    else $error("more than one first id match");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == spqt_pkg::CMD_INSERT) && !full |=>
      count == $past(count) + spqt_pkg::CNT_W'(1))
    else $error("accepted insert did not grow the queue");

  a_found_on_remove: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == spqt_pkg::CMD_REMOVE) && !empty && cell_link[N-1].found |->
      hit != '0)
    else $error("remove found a match but no cell selected");

endmodule

>>> rtl/spqt_cell.sv
// ----------------------------------------------------------------------------
// spqt_cell: one slot of the sorted queue
// Holds one entry, compares it with the broadcast request, and moves data
// to or from its neighbors on insert, pop and remove.
// ----------------------------------------------------------------------------
module spqt_cell (
  input  logic                clk,
  input  spqt_pkg::ctl_t      ctl,
  input  logic                occupied,
  input  spqt_pkg::entry_t    left_ent,
  input  spqt_pkg::link_t     left_link,
  input  spqt_pkg::entry_t    right_ent,
  output spqt_pkg::entry_t    ent,
  output spqt_pkg::link_t     link,
  output logic                first_hit
);

  logic match;

  // Slot sits at or past the insert point when empty or holding a larger value
  always_comb begin
    match      = occupied && (ent.id == ctl.id);
    link.shift = !occupied || (ent.pri > ctl.pri);
    link.found = left_link.found || match;
    first_hit  = match && !left_link.found;
  end

  // Entry storage: shift right on insert, shift left behind a removal
  always_ff @(posedge clk) begin
    if (ctl.act) begin
      case (ctl.op)
        spqt_pkg::CMD_INSERT: begin
          if (left_link.shift) begin
            ent <= left_ent;
          end else if (link.shift) begin
            ent <= '{id: ctl.id, pri: ctl.pri};
          end
        end
        spqt_pkg::CMD_POP: begin
          ent <= right_ent;
        end
        spqt_pkg::CMD_REMOVE: begin
          if (link.found) begin
            ent <= right_ent;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
